@@ hdl/qtt_pkg.sv @@
// ----------------------------------------------------------------------------
// qtt_pkg
// types and constants shared by the threshold tracker, its cells and command channel
// ----------------------------------------------------------------------------
package qtt_pkg;

    localparam int VALUE_W = 31;
    localparam int CMD_W   = 2;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [CMD_W-1:0]   cmd_t;

    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_REPORT = 2'd1;
    localparam cmd_t CMD_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE,
        CELL_TRIM,
        CELL_CLEAR
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t op;
        logic     trim;
        value_t   ins_value;
        value_t   wrap_value;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_REPORT
    } qtt_state_t;

endpackage

@@ hdl/qtt_in_if.sv @@
// ----------------------------------------------------------------------------
// qtt_in_if
// command channel: insert, report or clear beats
// ----------------------------------------------------------------------------
interface qtt_in_if;
    logic          valid;
    logic          ready;
    qtt_pkg::cmd_t cmd;
    logic [30:0]   value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

@@ hdl/qtt_out_if.sv @@
// ----------------------------------------------------------------------------
// qtt_out_if
// result channel: one beat per value; an empty report gets one with no value
// ----------------------------------------------------------------------------
interface qtt_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] value_out;
    logic        has_value;
    logic        last;

    modport source (output valid, output value_out, output has_value, output last,
                    input ready);
    modport sink   (input valid, input value_out, input has_value, input last,
                    output ready);
endinterface

@@ hdl/qtt_cell.sv @@
// ----------------------------------------------------------------------------
// qtt_cell
// one slot of the sorted chain; holds a value and a valid bit, shifts on
// insert and rotates towards the head during a report
// ----------------------------------------------------------------------------
module qtt_cell #(
    parameter bit TRIMMED = 1'b0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  qtt_pkg::cell_ctrl_t ctrl,
    input  logic                prev_gt,
    input  logic                prev_valid,
    input  qtt_pkg::value_t     prev_value,
    input  qtt_pkg::value_t     next_value,
    input  logic                active,
    input  logic                tail,
    output logic                gt,
    output qtt_pkg::value_t     value_next,
    output qtt_pkg::value_t     value_reg,
    output logic                valid_reg
);
    import qtt_pkg::*;

    logic valid_next;

    // an empty slot or a smaller value gives way to the new one
    assign gt = !valid_reg || (ctrl.ins_value > value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (gt)
                begin
                    value_next = prev_gt ? prev_value : ctrl.ins_value;
                    valid_next = prev_gt ? prev_valid : 1'b1;
                end
                if (ctrl.trim && TRIMMED)
                begin
                    valid_next = 1'b0;
                end
            end
            CELL_ROTATE:
            begin
                if (active)
                begin
                    value_next = tail ? ctrl.wrap_value : next_value;
                end
            end
            CELL_TRIM:
            begin
                if (TRIMMED)
                begin
                    valid_next = 1'b0;
                end
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                value_next = value_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

@@ hdl/top_q_threshold_tracker.sv @@
// order: an insert or clear takes effect in the cycle after its beat; a report
//   enters the report state, then registers its result beats, one a cycle while
//   the result channel is free; inserts and clears are taken one per cycle while
//   idle, and a report holds the command channel until its last beat is emitted
// reset: stored count, threshold and all slot valid bits clear at once
// ----------------------------------------------------------------------------
// top_q_threshold_tracker
// keeps the KEEP_COUNT largest values of a stream in a sorted chain of KEEP_COUNT
// + SLACK_SLOTS cells, with a threshold set when a report trims or the chain fills
// ----------------------------------------------------------------------------
module top_q_threshold_tracker #(
    parameter int KEEP_COUNT  = 32,
    parameter int SLACK_SLOTS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    qtt_in_if.sink    req,
    qtt_out_if.source rsp
);
    import qtt_pkg::*;

    localparam int TOTAL = KEEP_COUNT + SLACK_SLOTS;
    localparam int FW    = $clog2(TOTAL + 1);

    localparam logic [FW-1:0] FULL_M1  = FW'(TOTAL - 1);
    localparam logic [FW-1:0] KEEP_CNT = FW'(KEEP_COUNT);

    qtt_state_t    state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] idx_reg, idx_next;
    value_t        thr_reg, thr_next;
    logic          thr_set_reg, thr_set_next;

    logic          out_valid_reg, out_valid_next;
    value_t        out_value_reg, out_value_next;
    logic          out_has_reg, out_has_next;
    logic          out_last_reg, out_last_next;

    cell_ctrl_t    ctrl;
    logic          in_fire;
    logic          rsp_free;
    logic          emit;
    logic          emit_last;
    logic          empty_run;
    logic          ins_ok;

    logic   [TOTAL-1:0] gt_vec;
    logic   [TOTAL-1:0] valid_vec;
    value_t             val_vec  [TOTAL];
    value_t             vnext_vec[TOTAL];

    // ------------------------------------------------------------------
    // cell chain
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < TOTAL; gi++)
        begin : g_cell
            logic   p_gt;
            logic   p_valid;
            value_t p_value;
            value_t n_value;
            logic   act;
            logic   tl;

            if (gi == 0)
            begin : g_head
                assign p_gt    = 1'b0;
                assign p_valid = 1'b1;
                assign p_value = '0;
            end
            else
            begin : g_body
                assign p_gt    = gt_vec[gi-1];
                assign p_valid = valid_vec[gi-1];
                assign p_value = val_vec[gi-1];
            end

            if (gi == TOTAL - 1)
            begin : g_end
                assign n_value = '0;
            end
            else
            begin : g_mid
                assign n_value = val_vec[gi+1];
            end

            assign act = (FW'(gi) < fill_reg);
            assign tl  = (FW'(gi + 1) == fill_reg);

            qtt_cell #(
                .TRIMMED (gi >= KEEP_COUNT)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_gt    (p_gt),
                .prev_valid (p_valid),
                .prev_value (p_value),
                .next_value (n_value),
                .active     (act),
                .tail       (tl),
                .gt         (gt_vec[gi]),
                .value_next (vnext_vec[gi]),
                .value_reg  (val_vec[gi]),
                .valid_reg  (valid_vec[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // handshake terms
    // ------------------------------------------------------------------
    assign in_fire   = req.valid && req.ready;
    assign rsp_free  = !out_valid_reg || rsp.ready;
    assign emit      = (state_reg == ST_REPORT) && rsp_free;
    assign empty_run = (fill_reg == '0);
    assign emit_last = empty_run || (idx_reg == fill_reg - FW'(1));
    assign ins_ok    = !(thr_set_reg && (req.value < thr_reg));

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (req.cmd == CMD_REPORT))
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (emit && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the state machine: chain control and bookkeeping
    // ------------------------------------------------------------------
    always_comb
    begin
        req.ready       = (state_reg == ST_IDLE);
        ctrl.op         = CELL_HOLD;
        ctrl.trim       = 1'b0;
        ctrl.ins_value  = req.value;
        ctrl.wrap_value = val_vec[0];
        fill_next       = fill_reg;
        thr_next        = thr_reg;
        thr_set_next    = thr_set_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                ctrl.op = CELL_INSERT;
                                if (fill_reg == FULL_M1)
                                begin
                                    // chain full: keep the top slots, set threshold
                                    ctrl.trim    = 1'b1;
                                    fill_next    = KEEP_CNT;
                                    thr_next     = vnext_vec[KEEP_COUNT-1];
                                    thr_set_next = 1'b1;
                                end
                                else
                                begin
                                    fill_next = fill_reg + FW'(1);
                                end
                            end
                        end
                        CMD_REPORT:
                        begin
                            idx_next = '0;
                            if (fill_reg >= KEEP_CNT)
                            begin
                                ctrl.op      = CELL_TRIM;
                                fill_next    = KEEP_CNT;
                                thr_next     = val_vec[KEEP_COUNT-1];
                                thr_set_next = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ctrl.op      = CELL_CLEAR;
                            fill_next    = '0;
                            thr_next     = '0;
                            thr_set_next = 1'b0;
                        end
                        default:
                        begin
                            ctrl.op = CELL_HOLD;
                        end
                    endcase
                end
            end
            ST_REPORT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = empty_run ? '0 : val_vec[0];
                    out_has_next   = !empty_run;
                    out_last_next  = emit_last;
                    idx_next       = idx_reg + FW'(1);
                    // head goes out, the run rotates so it is intact at the end
                    if (!empty_run)
                    begin
                        ctrl.op = CELL_ROTATE;
                    end
                end
            end
            default:
            begin
                ctrl.op = CELL_HOLD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            thr_reg       <= '0;
            thr_set_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            thr_reg       <= thr_next;
            thr_set_reg   <= thr_set_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.value_out = out_value_reg;
    assign rsp.has_value = out_has_reg;
    assign rsp.last      = out_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fill_below_full: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_M1)
        else $error("stored count reached the full chain");

    a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(fill_reg))
        else $error("valid cells disagree with stored count");

    a_thr_implies_keep: assert property (@(posedge clk) disable iff (!rst_n)
        thr_set_reg |-> (fill_reg >= KEEP_CNT))
        else $error("threshold set with too few stored values");

    a_report_restores_head: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last && !empty_run && (idx_reg == '0)) |=> $stable(val_vec[0]))
        else $error("single-value run lost its head");

    generate
        for (gi = 1; gi < TOTAL; gi++)
        begin : g_sorted
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                (state_reg == ST_IDLE && valid_vec[gi]) |->
                    (valid_vec[gi-1] && (val_vec[gi-1] >= val_vec[gi])))
                else $error("chain out of order");
        end
    endgenerate

endmodule

@@ tb/sv/tb_top_q_threshold_tracker.sv @@
// ----------------------------------------------------------------------------
// tb_top_q_threshold_tracker
// self-checking bench for the top-k threshold tracker: a short table of
// directed commands, then random insert runs, reports, clears and noise,
// all checked beat by beat against a behavioural copy of the kept set
// ----------------------------------------------------------------------------
module tb_top_q_threshold_tracker;
    import qtt_pkg::*;

    localparam int KEEP_COUNT  = 32;
    localparam int SLACK_SLOTS = 32;
    localparam int TOTAL_SLOTS = KEEP_COUNT + SLACK_SLOTS;
    localparam int RAND_ITEMS  = 300;
    localparam int HALF_PERIOD = 10;
    localparam int DIR_ROWS    = 24;

    // the one command code the block must ignore
    localparam cmd_t   CMD_UNUSED = 2'd3;
    localparam value_t VALUE_MAX  = '1;

    typedef struct packed {
        value_t value_out;
        logic   has_value;
        logic   last;
    } result_t;

    typedef struct packed {
        cmd_t     cmd;
        value_t   val;
        logic [7:0] reps;
        logic     fixed;
        result_t  fixed_res;
    } dir_row_t;

    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_BLOCKS
    } rx_mode_t;

    localparam result_t NO_RES    = '0;
    localparam result_t EMPTY_RES = '{value_out: '0, has_value: 1'b0, last: 1'b1};
    localparam result_t ZERO_RES  = '{value_out: '0, has_value: 1'b1, last: 1'b1};
    localparam result_t MAX_RES   = '{value_out: VALUE_MAX, has_value: 1'b1, last: 1'b1};

    // values step by one per repeat within a row
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{CMD_REPORT, 31'd0,          8'd1,  1'b1, EMPTY_RES},
        '{CMD_UNUSED, VALUE_MAX,      8'd1,  1'b0, NO_RES},
        '{CMD_REPORT, 31'd0,          8'd1,  1'b1, EMPTY_RES},
        '{CMD_INSERT, VALUE_MAX,      8'd1,  1'b0, NO_RES},
        '{CMD_REPORT, 31'd1,          8'd1,  1'b1, MAX_RES},
        '{CMD_CLEAR,  VALUE_MAX,      8'd1,  1'b0, NO_RES},
        '{CMD_INSERT, 31'd0,          8'd1,  1'b0, NO_RES},
        '{CMD_REPORT, 31'd0,          8'd1,  1'b1, ZERO_RES},
        '{CMD_INSERT, 31'd0,          8'd1,  1'b0, NO_RES},
        '{CMD_INSERT, 31'h5555_5555,  8'd1,  1'b0, NO_RES},
        '{CMD_INSERT, 31'h2aaa_aaaa,  8'd1,  1'b0, NO_RES},
        '{CMD_REPORT, 31'd0,          8'd1,  1'b0, NO_RES},
        '{CMD_CLEAR,  31'd0,          8'd1,  1'b0, NO_RES},
        '{CMD_REPORT, 31'd0,          8'd1,  1'b1, EMPTY_RES},
        '{CMD_INSERT, 31'd1000,       8'd32, 1'b0, NO_RES},
        '{CMD_REPORT, 31'd0,          8'd1,  1'b0, NO_RES},
        '{CMD_INSERT, 31'd1000,       8'd1,  1'b0, NO_RES},
        '{CMD_INSERT, 31'd999,        8'd1,  1'b0, NO_RES},
        '{CMD_REPORT, 31'd0,          8'd1,  1'b0, NO_RES},
        '{CMD_INSERT, 31'd0,          8'd1,  1'b0, NO_RES},
        '{CMD_REPORT, 31'd0,          8'd1,  1'b0, NO_RES},
        '{CMD_CLEAR,  31'd0,          8'd1,  1'b0, NO_RES},
        '{CMD_INSERT, 31'd0,          8'd1,  1'b0, NO_RES},
        '{CMD_REPORT, 31'd0,          8'd1,  1'b1, ZERO_RES}
    };

    logic clk;
    logic rst_n;

    qtt_in_if  req_if ();
    qtt_out_if rsp_if ();

    top_q_threshold_tracker #(
        .KEEP_COUNT  (KEEP_COUNT),
        .SLACK_SLOTS (SLACK_SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // behavioural copy of the kept set
    value_t  kept [TOTAL_SLOTS];
    int      kept_fill = 0;
    value_t  cut_level = '0;
    logic    cut_armed = 1'b0;
    result_t pending_res [$];

    int       err_count     = 0;
    logic     beat_fixed    = 1'b0;
    result_t  beat_fixed_res = '0;
    int       burst_left    = 0;
    rx_mode_t rx_mode       = RX_OPEN;
    int       rx_mode_left  = 0;
    int       rx_stall_left = 0;

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    function automatic void sort_kept();
        int     i;
        int     j;
        value_t v;
        for (i = 1; i < kept_fill; i++)
        begin
            v = kept[i];
            j = i;
            while (j > 0 && kept[j-1] < v)
            begin
                kept[j] = kept[j-1];
                j--;
            end
            kept[j] = v;
        end
    endfunction

    function automatic void trim_to_keep();
        sort_kept();
        cut_level = kept[KEEP_COUNT-1];
        cut_armed = 1'b1;
        kept_fill = KEEP_COUNT;
    endfunction

    function automatic void tracker_step(cmd_t cmd, value_t val);
        result_t r;
        int      i;
        case (cmd)
            CMD_INSERT:
            begin
                if (!(cut_armed && val < cut_level))
                begin
                    kept[kept_fill] = val;
                    kept_fill++;
                    if (kept_fill == TOTAL_SLOTS)
                        trim_to_keep();
                end
            end
            CMD_REPORT:
            begin
                if (kept_fill == 0)
                    pending_res.push_back(EMPTY_RES);
                else
                begin
                    if (kept_fill >= KEEP_COUNT)
                        trim_to_keep();
                    else
                        sort_kept();
                    for (i = 0; i < kept_fill; i++)
                    begin
                        r.value_out = kept[i];
                        r.has_value = 1'b1;
                        r.last      = (i == kept_fill - 1);
                        pending_res.push_back(r);
                    end
                end
            end
            CMD_CLEAR:
            begin
                kept_fill = 0;
                cut_level = '0;
                cut_armed = 1'b0;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic record_command();
        int mark;
        mark = pending_res.size();
        tracker_step(req_if.cmd, req_if.value);
        // rows with a typed result replace what the model worked out
        if (beat_fixed)
        begin
            while (pending_res.size() > mark)
                void'(pending_res.pop_back());
            pending_res.push_back(beat_fixed_res);
        end
    endtask

    task automatic check_beat();
        result_t want;
        if (pending_res.size() == 0)
            report_mismatch($sformatf("unexpected beat value_out %0h has_value %0b last %0b",
                                      rsp_if.value_out, rsp_if.has_value, rsp_if.last));
        else
        begin
            want = pending_res.pop_front();
            if (rsp_if.value_out !== want.value_out)
                report_mismatch($sformatf("value_out %0h, want %0h",
                                          rsp_if.value_out, want.value_out));
            if (rsp_if.has_value !== want.has_value)
                report_mismatch($sformatf("has_value %0b, want %0b",
                                          rsp_if.has_value, want.has_value));
            if (rsp_if.last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", rsp_if.last, want.last));
        end
    endtask

    // commands first, so a result is always predicted before it is checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                record_command();
            if (rsp_if.valid && rsp_if.ready)
                check_beat();
        end
    end

    // receiver: open, coin toss, or occasional long blocks
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(20, 120);
        end
        else
            rx_mode_left--;
        if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            rsp_if.ready <= 1'b0;
        end
        else
            case (rx_mode)
                RX_OPEN: rsp_if.ready <= 1'b1;
                RX_COIN: rsp_if.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        rx_stall_left = $urandom_range(3, 15);
                        rsp_if.ready <= 1'b0;
                    end
                    else
                        rsp_if.ready <= 1'b1;
                end
            endcase
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic drive_beat(input cmd_t cmd, input value_t val, input logic fixed,
                              input result_t fixed_res);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_if.valid   <= 1'b1;
        req_if.cmd     <= cmd;
        req_if.value   <= val;
        beat_fixed     = fixed;
        beat_fixed_res = fixed_res;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
    endtask

    // hold the sender off until every predicted beat has come back
    task automatic settle_drained();
        req_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_res.size() != 0);
        burst_left = 0;
    endtask

    // values around the live threshold, extremes, small repeats and full-range random values
    function automatic value_t pick_value();
        value_t v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = VALUE_MAX;
            2: v = cut_level;
            3: v = (cut_level > VALUE_MAX - 4) ? cut_level
                                               : cut_level + value_t'($urandom_range(1, 4));
            4: v = (cut_level == '0) ? '0 : cut_level - 1'b1;
            5: v = value_t'($urandom_range(0, 63));
            default: v = value_t'($urandom());
        endcase
        return v;
    endfunction

    initial
    begin
        int   row;
        int   k;
        int   rand_items;
        int   run_len;
        logic paused;
        cmd_t c;

        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.cmd    = CMD_INSERT;
        req_if.value  = '0;
        rsp_if.ready  = 1'b0;
        rand_items    = 0;
        paused        = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        for (row = 0; row < DIR_ROWS; row++)
            for (k = 0; k < dir_tab[row].reps; k++)
                drive_beat(dir_tab[row].cmd, dir_tab[row].val + value_t'(k),
                           dir_tab[row].fixed, dir_tab[row].fixed_res);
        settle_drained();

        while (rand_items < RAND_ITEMS)
        begin
            if (!paused && rand_items >= RAND_ITEMS / 2)
            begin
                settle_drained();
                paused = 1'b1;
            end
            case ($urandom_range(0, 19))
                13, 14:
                begin
                    drive_beat(CMD_REPORT, value_t'($urandom()), 1'b0, NO_RES);
                    rand_items++;
                end
                15:
                begin
                    drive_beat(CMD_CLEAR, value_t'($urandom()), 1'b0, NO_RES);
                    rand_items++;
                end
                16: drive_beat(CMD_UNUSED, value_t'($urandom()), 1'b0, NO_RES);
                17, 18, 19:
                begin
                    // noise: any command code, any value
                    run_len = $urandom_range(1, 8);
                    for (k = 0; k < run_len; k++)
                    begin
                        c = cmd_t'($urandom_range(0, 3));
                        drive_beat(c, value_t'($urandom()), 1'b0, NO_RES);
                        if (c != CMD_UNUSED)
                            rand_items++;
                    end
                end
                default:
                begin
                    run_len = $urandom_range(4, 40);
                    for (k = 0; k < run_len; k++)
                    begin
                        drive_beat(CMD_INSERT, pick_value(), 1'b0, NO_RES);
                        rand_items++;
                    end
                    if ($urandom_range(0, 1) == 1)
                    begin
                        drive_beat(CMD_REPORT, value_t'($urandom()), 1'b0, NO_RES);
                        rand_items++;
                    end
                end
            endcase
        end

        settle_drained();
        repeat (2 * TOTAL_SLOTS) @(negedge clk);
        if (err_count == 0)
            $display("tb_top_q_threshold_tracker: done, clean");
        else
            $display("tb_top_q_threshold_tracker: done, errors");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("tb_top_q_threshold_tracker: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
hdl/qtt_pkg.sv
hdl/qtt_in_if.sv
hdl/qtt_out_if.sv
hdl/qtt_cell.sv
hdl/top_q_threshold_tracker.sv
tb/sv/tb_top_q_threshold_tracker.sv
